>>> hw/rtl/fhf_pkg.sv
`timescale 1ns / 1ps
// fhf_pkg: shared types, codes and heat helpers for the fire heat field update block
package fhf_pkg;

	// command codes
	localparam logic [1:0] FUNC_SPARK = 2'd0;
	localparam logic [1:0] FUNC_FRAME = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;
	localparam logic [1:0] FUNC_CLEAR = 2'd3;

	// configuration register map
	localparam int         PADDR_W        = 3;
	localparam logic       REG_IDX_WIDTH  = 1'b0;
	localparam logic       REG_IDX_HEIGHT = 1'b1;
	localparam logic [7:0] WIDTH_RESET    = 8'd80;
	localparam logic [6:0] HEIGHT_RESET   = 7'd24;

	// heat scale
	localparam logic [6:0] HEAT_MAX   = 7'd65;
	localparam logic [6:0] GLYPH_MAX  = 7'd9;
	localparam logic [6:0] GREY_TOP   = 7'd4;
	localparam logic [6:0] RED_TOP    = 7'd9;
	localparam logic [6:0] YELLOW_TOP = 7'd15;

	localparam logic [2:0] COLOR_BLACK  = 3'd0;
	localparam logic [2:0] COLOR_GREY   = 3'd1;
	localparam logic [2:0] COLOR_RED    = 3'd2;
	localparam logic [2:0] COLOR_YELLOW = 3'd3;
	localparam logic [2:0] COLOR_WHITE  = 3'd4;

	typedef logic [6:0] heat_t;

	function automatic logic [3:0] heat_glyph(input heat_t h);
		logic [3:0] g;
		if (h > GLYPH_MAX) g = GLYPH_MAX[3:0];
		else               g = h[3:0];
		return g;
	endfunction

	function automatic logic [2:0] heat_color(input heat_t h);
		logic [2:0] c;
		if (h == 7'd0)            c = COLOR_BLACK;
		else if (h <= GREY_TOP)   c = COLOR_GREY;
		else if (h <= RED_TOP)    c = COLOR_RED;
		else if (h <= YELLOW_TOP) c = COLOR_YELLOW;
		else                      c = COLOR_WHITE;
		return c;
	endfunction

endpackage

>>> hw/rtl/fhf_if.sv
`timescale 1ns / 1ps
// fhf_if: command and response channel interfaces
interface fhf_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [6:0] spark_column;
	logic [6:0] read_x;
	logic [5:0] read_y;

	modport source (output valid, func, spark_column, read_x, read_y, input ready);
	modport sink   (input valid, func, spark_column, read_x, read_y, output ready);
endinterface

interface fhf_rsp_if;
	logic       valid;
	logic       ready;
	logic [6:0] heat;
	logic [3:0] glyph_code;
	logic [2:0] color_class;

	modport source (output valid, heat, glyph_code, color_class, input ready);
	modport sink   (input valid, heat, glyph_code, color_class, output ready);
endinterface

>>> hw/rtl/fire_heat_field_update_top.sv
`timescale 1ns / 1ps
// fire_heat_field_update_top: heat field store with spark, frame step, read and clear
//
//  channel | dir | handshake          | word
//  --------+-----+--------------------+--------------------------------------------
//  cmd     | in  | valid / ready      | func, spark_column, read_x, read_y
//  rsp     | out | valid / ready      | heat, glyph_code, color_class (reads only)
//  apb     | in  | psel/penable/pwrite| frame_width @0x0, frame_height @0x4
//
// a read holds in its data state until rsp can take the word; the frame step streams one
//   cell a cycle through the single write port of the heat memory
// reset: the memory is swept to zero, all MAX_WIDTH*MAX_HEIGHT cells (8192 by default),
//   before cmd.ready rises; a resize write starts the same sweep
// stalls: a finished read word waits in the rsp register while the next word is taken
module fire_heat_field_update_top #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	fhf_cmd_if.sink                      cmd,
	fhf_rsp_if.source                    rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [fhf_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import fhf_pkg::*;

	localparam int Cells = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(Cells);
	localparam int PW    = AW + 1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SPARK,
		ST_RD_ADDR,
		ST_RD_DATA,
		ST_SW_INIT,
		ST_SWEEP
	} state_t;

	state_t state_q;

	// ---------------- configuration ----------------
	logic [7:0] frame_width_q;
	logic [6:0] frame_height_q;
	logic [7:0] w_eff;
	logic [6:0] h_eff;
	logic [7:0] new_w_eff;
	logic [6:0] new_h_eff;
	logic       cfg_wr;
	logic       resize_clr;

	// oversized registers act as the maximum
	always_comb begin
		w_eff     = (32'(frame_width_q) > MAX_WIDTH) ? 8'(MAX_WIDTH) : frame_width_q;
		h_eff     = (32'(frame_height_q) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : frame_height_q;
		new_w_eff = (32'(pwdata[7:0]) > MAX_WIDTH) ? 8'(MAX_WIDTH) : pwdata[7:0];
		new_h_eff = (32'(pwdata[6:0]) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : pwdata[6:0];
	end

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// a change of the effective size wipes the store
	always_comb begin
		resize_clr = 1'b0;
		if (cfg_wr) begin
			if (paddr[2] == REG_IDX_WIDTH) resize_clr = (new_w_eff != w_eff);
			else                           resize_clr = (new_h_eff != h_eff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WIDTH_RESET;
			frame_height_q <= HEIGHT_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_IDX_WIDTH) frame_width_q  <= pwdata[7:0];
			else                           frame_height_q <= pwdata[6:0];
		end
	end

	always_comb begin
		if (paddr[2] == REG_IDX_WIDTH) prdata = {24'd0, frame_width_q};
		else                           prdata = {25'd0, frame_height_q};
	end

	// ---------------- heat memory ----------------
	heat_t           heat_mem [Cells];
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	heat_t           wr_data;
	logic [AW-1:0]   rd_a_addr;
	logic [AW-1:0]   rd_b_addr;
	heat_t           rd_a_data;
	heat_t           rd_b_data;

	always_ff @(posedge clk) begin
		if (wr_en) heat_mem[wr_addr] <= wr_data;
		rd_a_data <= heat_mem[rd_a_addr];
		rd_b_data <= heat_mem[rd_b_addr];
	end

	// ---------------- item registers ----------------
	logic [6:0]    spark_col_q;
	logic [6:0]    rx_q;
	logic [5:0]    ry_q;
	logic          rd_hit_q;
	logic [PW-1:0] pos_q;        // clear and sweep cursor
	logic [PW-1:0] active_q;     // cells in the field for this sweep
	logic [PW-1:0] top_q;        // cells in the rows that cool in the sweep

	// sweep read stage
	logic          sw_valid_s1;
	logic          a_ok_s1;
	logic          b_ok_s1;
	logic [PW-1:0] pos_s1;
	heat_t         prev_a_q;
	heat_t         prev_b_q;

	logic          cmd_take;
	logic          sw_issue;
	logic [PW-1:0] b_idx;
	logic [13:0]   rd_idx;
	logic [14:0]   spark_idx;
	logic          spark_ok;
	heat_t         cur_a;
	heat_t         cur_b;
	logic [8:0]    sum4;
	heat_t         avg;
	heat_t         cooled;
	logic [PW-1:0] sw_wr_idx;
	heat_t         rd_heat;
	logic          rsp_free;
	logic          rsp_valid_q;
	heat_t         heat_q;
	logic [3:0]    glyph_q;
	logic [2:0]    color_q;

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_take  = cmd.valid && cmd.ready;

	assign b_idx     = pos_q + PW'(w_eff);
	assign sw_issue  = (state_q == ST_SWEEP) && (pos_q <= active_q);
	assign rd_idx    = 14'(ry_q) * 14'(w_eff) + 14'(rx_q);
	assign spark_idx = 15'(w_eff) * 15'(h_eff - 7'd1) + 15'(spark_col_q);
	assign spark_ok  = (w_eff != 8'd0) && (h_eff != 7'd0) && ({1'b0, spark_col_q} < w_eff);

	// four cells: cells past the field read zero
	assign cur_a     = a_ok_s1 ? rd_a_data : 7'd0;
	assign cur_b     = b_ok_s1 ? rd_b_data : 7'd0;
	assign sum4      = 9'(prev_a_q) + 9'(cur_a) + 9'(prev_b_q) + 9'(cur_b);
	assign sw_wr_idx = pos_s1 - PW'(1);

	always_comb begin
		avg = sum4[8:2];
		if (avg > HEAT_MAX) avg = HEAT_MAX;
		// top rows cool by one after averaging; folded into the same write
		cooled = avg;
		if ((sw_wr_idx < top_q) && (avg != 7'd0)) cooled = avg - 7'd1;
	end

	// memory port steering
	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = pos_q[AW-1:0];
		wr_data   = 7'd0;
		rd_a_addr = pos_q[AW-1:0];
		rd_b_addr = b_idx[AW-1:0];
		case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
			end
			ST_SPARK: begin
				wr_en   = spark_ok;
				wr_addr = AW'(spark_idx);
				wr_data = HEAT_MAX;
			end
			ST_RD_ADDR, ST_RD_DATA: begin
				rd_a_addr = AW'(rd_idx);
			end
			ST_SWEEP: begin
				wr_en   = sw_valid_s1 && (pos_s1 != '0);
				wr_addr = sw_wr_idx[AW-1:0];
				wr_data = cooled;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// sweep stage one: what came back from the memory this cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_valid_s1 <= 1'b0;
		end else begin
			sw_valid_s1 <= sw_issue;
		end
	end

	always_ff @(posedge clk) begin
		a_ok_s1 <= pos_q < active_q;
		b_ok_s1 <= b_idx < active_q;
		pos_s1  <= pos_q;
		if (sw_valid_s1) begin
			prev_a_q <= cur_a;
			prev_b_q <= cur_b;
		end
	end

	assign rd_heat  = rd_hit_q ? ((rd_a_data > HEAT_MAX) ? HEAT_MAX : rd_a_data) : 7'd0;
	assign rsp_free = !rsp_valid_q || rsp.ready;

	// control and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			pos_q       <= '0;
			active_q    <= '0;
			top_q       <= '0;
			spark_col_q <= '0;
			rx_q        <= '0;
			ry_q        <= '0;
			rd_hit_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
			heat_q      <= '0;
			glyph_q     <= '0;
			color_q     <= '0;
		end else begin
			if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					pos_q <= pos_q + PW'(1);
					if (pos_q == PW'(Cells - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cmd_take) begin
						spark_col_q <= cmd.spark_column;
						rx_q        <= cmd.read_x;
						ry_q        <= cmd.read_y;
						pos_q       <= '0;
						case (cmd.func)
							FUNC_SPARK: state_q <= ST_SPARK;
							FUNC_FRAME: state_q <= ST_SW_INIT;
							FUNC_READ:  state_q <= ST_RD_ADDR;
							FUNC_CLEAR: state_q <= ST_CLEAR;
							default:    state_q <= ST_IDLE;
						endcase
					end
				end
				ST_SPARK: begin
					state_q <= ST_IDLE;
				end
				ST_RD_ADDR: begin
					rd_hit_q <= ({1'b0, rx_q} < w_eff) && ({1'b0, ry_q} < h_eff);
					state_q  <= ST_RD_DATA;
				end
				ST_RD_DATA: begin
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						heat_q      <= rd_heat;
						glyph_q     <= heat_glyph(rd_heat);
						color_q     <= heat_color(rd_heat);
						state_q     <= ST_IDLE;
					end
				end
				ST_SW_INIT: begin
					active_q <= PW'(15'(w_eff) * 15'(h_eff));
					top_q    <= (h_eff >= 7'd2) ? PW'({w_eff, 1'b0}) : PW'(w_eff);
					state_q  <= ST_SWEEP;
				end
				ST_SWEEP: begin
					if (sw_issue) pos_q <= pos_q + PW'(1);
					// last word read back is the one just past the field
					if (sw_valid_s1 && (pos_s1 == active_q)) begin
						pos_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (resize_clr) begin
				pos_q   <= '0;
				state_q <= ST_CLEAR;
			end
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.heat        = heat_q;
	assign rsp.glyph_code  = glyph_q;
	assign rsp.color_class = color_q;

endmodule

>>> hw/rtl/fhf_checker.sv
`timescale 1ns / 1ps
// fhf_checker: port-level assertions for the fire heat field update block, with its bind
module fhf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_ready,
	input logic [1:0] cmd_func,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [6:0] heat,
	input logic [3:0] glyph_code,
	input logic [2:0] color_class
);
	import fhf_pkg::*;

	// a stalled response word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(heat))
		else $error("response word dropped or changed while stalled");

	// glyph follows heat
	a_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> glyph_code == heat_glyph(heat))
		else $error("glyph code does not match heat");

	// color class follows heat, heat within scale
	a_color: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (color_class == heat_color(heat)) && (heat <= HEAT_MAX))
		else $error("color class or heat out of line");

	// a taken clear command drops the command side's ready
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd_func == FUNC_CLEAR) |=> !cmd_ready)
		else $error("command taken during store clear");

endmodule

bind fire_heat_field_update_top fhf_checker u_fhf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd.valid),
	.cmd_ready   (cmd.ready),
	.cmd_func    (cmd.func),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.heat        (rsp.heat),
	.glyph_code  (rsp.glyph_code),
	.color_class (rsp.color_class)
);
